FILE: hdl/rigid_point_transform_unit_macros.svh
// Assertion macros for the rigid point transform top level.
`ifndef RIGID_POINT_TRANSFORM_UNIT_MACROS_SVH
`define RIGID_POINT_TRANSFORM_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rptu_pkg.sv
// Package with widths, codes and types shared by the rigid point transform.
package rptu_pkg;

    localparam int COORD_W    = 32;
    localparam int ENTRY_W    = 18;
    localparam int COEF_W     = 22;
    localparam int QUAT_W     = 16;
    localparam int QSUM_W     = 35;
    localparam int Q28_SHIFT  = 12;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = COEF_W + DIFF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_W     = 16;
    localparam int MODE_W     = 2;
    localparam int ROW_W      = 3 * ENTRY_W;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [COEF_W-1:0]        ONE_Q16    = COEF_W'(1 << FRAC_W);
    localparam logic signed [QSUM_W-1:0] ONE_Q28    = QSUM_W'(1) <<< 28;
    localparam logic signed [QSUM_W-1:0] HALF_Q28   = QSUM_W'(1) <<< (Q28_SHIFT - 1);
    localparam logic signed [ACC_W-1:0]  HALF_ACC   = ACC_W'(1) <<< (FRAC_W - 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_CENTER_TRANSPOSE = 2'd0,
        MODE_ROTATE_ADD       = 2'd1,
        MODE_QUAT             = 2'd2,
        MODE_BYPASS           = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_ROW0     = 3'd1,
        REG_ROW1     = 3'd2,
        REG_ROW2     = 3'd3,
        REG_CENTER_X = 3'd4,
        REG_CENTER_Y = 3'd5,
        REG_CENTER_Z = 3'd6,
        REG_ROTOR    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        mode_t                          mode;
        logic [2:0][2:0][COEF_W-1:0]    mat;
        logic [2:0][2:0][COEF_W-1:0]    qmat;
        logic [2:0][COORD_W-1:0]        center;
    } cfg_t;

    typedef struct packed {
        logic [2:0][2:0][PROD_W-1:0]    prod;
        logic [2:0][COORD_W-1:0]        point;
    } prod_beat_t;

endpackage

FILE: hdl/rptu_cfg_regs.sv
// Configuration registers and the rotation matrix derived from the quaternion.
module rptu_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [rptu_pkg::IDX_W-1:0]         cfg_index,
    input  logic [rptu_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rptu_pkg::cfg_t                     cfg
);
    import rptu_pkg::*;

    mode_t                          mode_reg, mode_next;
    logic [2:0][ROW_W-1:0]          row_reg, row_next;
    logic [2:0][COORD_W-1:0]        center_reg, center_next;
    logic [2:0][2:0][COEF_W-1:0]    qmat_reg, qmat_next;

    function automatic logic [COEF_W-1:0] round_q28(input logic signed [QSUM_W-1:0] v);
        logic signed [QSUM_W-1:0] t;
        t = (v + HALF_Q28) >>> Q28_SHIFT;
        return t[COEF_W-1:0];
    endfunction

    function automatic logic [2:0][2:0][COEF_W-1:0] quat_matrix(
        input logic [CFG_DATA_W-1:0] q
    );
        logic signed [QUAT_W-1:0]   w, x, y, z;
        logic signed [2*QUAT_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
        logic signed [QSUM_W-1:0]   exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
        logic [2:0][2:0][COEF_W-1:0] m;
        w = q[QUAT_W-1:0];
        x = q[2*QUAT_W-1:QUAT_W];
        y = q[3*QUAT_W-1:2*QUAT_W];
        z = q[4*QUAT_W-1:3*QUAT_W];
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        exx = QSUM_W'(xx);
        eyy = QSUM_W'(yy);
        ezz = QSUM_W'(zz);
        exy = QSUM_W'(xy);
        exz = QSUM_W'(xz);
        eyz = QSUM_W'(yz);
        ewx = QSUM_W'(wx);
        ewy = QSUM_W'(wy);
        ewz = QSUM_W'(wz);
        m[0][0] = round_q28(ONE_Q28 - ((eyy + ezz) <<< 1));
        m[0][1] = round_q28((exy - ewz) <<< 1);
        m[0][2] = round_q28((exz + ewy) <<< 1);
        m[1][0] = round_q28((exy + ewz) <<< 1);
        m[1][1] = round_q28(ONE_Q28 - ((ezz + exx) <<< 1));
        m[1][2] = round_q28((eyz - ewx) <<< 1);
        m[2][0] = round_q28((exz - ewy) <<< 1);
        m[2][1] = round_q28((eyz + ewx) <<< 1);
        m[2][2] = round_q28(ONE_Q28 - ((eyy + exx) <<< 1));
        return m;
    endfunction

    always_comb
    begin
        mode_next   = mode_reg;
        row_next    = row_reg;
        center_next = center_reg;
        qmat_next   = qmat_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:     mode_next      = mode_t'(cfg_data[MODE_W-1:0]);
                REG_ROW0:     row_next[0]    = cfg_data[ROW_W-1:0];
                REG_ROW1:     row_next[1]    = cfg_data[ROW_W-1:0];
                REG_ROW2:     row_next[2]    = cfg_data[ROW_W-1:0];
                REG_CENTER_X: center_next[0] = cfg_data[COORD_W-1:0];
                REG_CENTER_Y: center_next[1] = cfg_data[COORD_W-1:0];
                REG_CENTER_Z: center_next[2] = cfg_data[COORD_W-1:0];
                REG_ROTOR:    qmat_next      = quat_matrix(cfg_data);
                default:      mode_next      = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_CENTER_TRANSPOSE;
            row_reg    <= {ROW_W'(ONE_Q16[ENTRY_W-1:0]) << (2 * ENTRY_W),
                           ROW_W'(ONE_Q16[ENTRY_W-1:0]) << ENTRY_W,
                           ROW_W'(ONE_Q16[ENTRY_W-1:0])};
            center_reg <= '0;
            qmat_reg   <= {{ONE_Q16, {COEF_W{1'b0}}, {COEF_W{1'b0}}},
                           {{COEF_W{1'b0}}, ONE_Q16, {COEF_W{1'b0}}},
                           {{COEF_W{1'b0}}, {COEF_W{1'b0}}, ONE_Q16}};
        end
        else
        begin
            mode_reg   <= mode_next;
            row_reg    <= row_next;
            center_reg <= center_next;
            qmat_reg   <= qmat_next;
        end
    end

    always_comb
    begin
        cfg.mode   = mode_reg;
        cfg.qmat   = qmat_reg;
        cfg.center = center_reg;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cfg.mat[i][j] = COEF_W'($signed(row_reg[i][j*ENTRY_W +: ENTRY_W]));
            end
        end
    end

endmodule

FILE: hdl/rptu_product_stage.sv
// Operand selection and the nine coefficient products, registered.
module rptu_product_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rptu_pkg::cfg_t                      cfg,
    input  logic                                a_vld,
    input  logic [2:0][rptu_pkg::COORD_W-1:0]   a_point,
    input  logic                                c_ready,
    output logic                                b_ready,
    output logic                                b_vld,
    output rptu_pkg::prod_beat_t                b_data
);
    import rptu_pkg::*;

    logic                       b_vld_reg, b_vld_next;
    prod_beat_t                 b_data_reg, b_data_next;
    logic signed [DIFF_W-1:0]   opnd [3];
    logic signed [COEF_W-1:0]   coef [3][3];
    logic signed [PROD_W-1:0]   sprod [3][3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (cfg.mode == MODE_CENTER_TRANSPOSE)
            begin
                opnd[j] = DIFF_W'($signed(a_point[j])) - DIFF_W'($signed(cfg.center[j]));
            end
            else
            begin
                opnd[j] = DIFF_W'($signed(a_point[j]));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                case (cfg.mode)
                    MODE_CENTER_TRANSPOSE: coef[i][j] = $signed(cfg.mat[j][i]);
                    MODE_QUAT:             coef[i][j] = $signed(cfg.qmat[i][j]);
                    default:               coef[i][j] = $signed(cfg.mat[i][j]);
                endcase
                sprod[i][j] = PROD_W'(coef[i][j]) * PROD_W'(opnd[j]);
                b_data_next.prod[i][j] = sprod[i][j];
            end
        end
        b_data_next.point = a_point;
    end

    assign b_ready    = !b_vld_reg || c_ready;
    assign b_vld_next = b_ready ? a_vld : b_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= b_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_vld)
        begin
            b_data_reg <= b_data_next;
        end
    end

    assign b_vld  = b_vld_reg;
    assign b_data = b_data_reg;

endmodule

FILE: hdl/rptu_output_stage.sv
// Dot product sums, rounding, saturation and the result register.
module rptu_output_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  rptu_pkg::cfg_t                      cfg,
    input  logic                                b_vld,
    input  rptu_pkg::prod_beat_t                b_data,
    input  logic                                out_stall,
    output logic                                c_ready,
    output logic                                out_vld,
    output logic [2:0][rptu_pkg::COORD_W-1:0]   moved
);
    import rptu_pkg::*;

    logic                       out_vld_reg, out_vld_next;
    logic [2:0][COORD_W-1:0]    moved_reg, moved_next;
    logic signed [ACC_W-1:0]    acc [3];
    logic signed [ACC_W-1:0]    rnd [3];
    logic [ACC_W-COORD_W:0]     high [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = ACC_W'($signed(b_data.prod[i][0]))
                   + ACC_W'($signed(b_data.prod[i][1]))
                   + ACC_W'($signed(b_data.prod[i][2]));
            if (cfg.mode == MODE_ROTATE_ADD)
            begin
                acc[i] = acc[i] + (ACC_W'($signed(cfg.center[i])) <<< FRAC_W);
            end
            rnd[i]  = (acc[i] + HALF_ACC) >>> FRAC_W;
            high[i] = rnd[i][ACC_W-1:COORD_W-1];
            if (cfg.mode == MODE_BYPASS)
            begin
                moved_next[i] = b_data.point[i];
            end
            else if ((&high[i]) || !(|high[i]))
            begin
                moved_next[i] = rnd[i][COORD_W-1:0];
            end
            else if (rnd[i][ACC_W-1])
            begin
                moved_next[i] = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                moved_next[i] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    assign c_ready      = !out_vld_reg || !out_stall;
    assign out_vld_next = c_ready ? b_vld : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_vld)
        begin
            moved_reg <= moved_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign moved   = moved_reg;

endmodule

FILE: hdl/rigid_point_transform_unit.sv
// Top level of the rigid point transform: input register, two compute stages, config.
// A beat passes the input, product and result registers in order; out_valid rises at the last.
// Throughput is one point per cycle while out_stall is low; the nine products run in parallel.
// Reset clears all valid flags and loads the identity matrix, zero centroid and mode 0.
// Configuration writes take effect in the next cycle and are always ready.
`include "rigid_point_transform_unit_macros.svh"

module rigid_point_transform_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rptu_pkg::IDX_W-1:0]          cfg_index,
    input  logic [rptu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rptu_pkg::COORD_W-1:0] point_x,
    input  logic signed [rptu_pkg::COORD_W-1:0] point_y,
    input  logic signed [rptu_pkg::COORD_W-1:0] point_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rptu_pkg::COORD_W-1:0] moved_x,
    output logic signed [rptu_pkg::COORD_W-1:0] moved_y,
    output logic signed [rptu_pkg::COORD_W-1:0] moved_z
);
    import rptu_pkg::*;

    cfg_t                       cfg;
    logic                       a_vld_reg, a_vld_next;
    logic [2:0][COORD_W-1:0]    a_point_reg;
    logic                       a_ready;
    logic                       b_ready;
    logic                       b_vld;
    prod_beat_t                 b_data;
    logic                       c_ready;
    logic [2:0][COORD_W-1:0]    moved;

    assign cfg_ready = 1'b1;

    rptu_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign a_ready    = !a_vld_reg || b_ready;
    assign in_stall   = !a_ready;
    assign a_vld_next = a_ready ? in_valid : a_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_point_reg <= {point_z, point_y, point_x};
        end
    end

    rptu_product_stage u_prod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .a_vld   (a_vld_reg),
        .a_point (a_point_reg),
        .c_ready (c_ready),
        .b_ready (b_ready),
        .b_vld   (b_vld),
        .b_data  (b_data)
    );

    rptu_output_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .b_vld     (b_vld),
        .b_data    (b_data),
        .out_stall (out_stall),
        .c_ready   (c_ready),
        .out_vld   (out_valid),
        .moved     (moved)
    );

    assign moved_x = moved[0];
    assign moved_y = moved[1];
    assign moved_z = moved[2];

    `RPTU_ASSERT_NOW(full_pipe_stalls_input,
        a_vld_reg && b_vld && out_valid && out_stall, in_stall,
        "Input not stalled while every stage is full and the output is blocked.")
    `RPTU_ASSERT_NEXT(accepted_beat_enters,
        in_valid && !in_stall, a_vld_reg,
        "Accepted input beat did not reach the input register.")
    `RPTU_ASSERT_NEXT(products_reach_output,
        b_vld && !(out_valid && out_stall), out_valid,
        "Product beat was dropped on its way to the result register.")

endmodule
